// ===== rtl/core/zpim_pkg.sv =====
// ----------------------------------------------------------------------------
// zpim_pkg
// Shared types and constants for the zoom pointer inverse map block.
// ----------------------------------------------------------------------------
`default_nettype none

package zpim_pkg;

    localparam int COORD_W = 16;
    localparam int VIEW_W  = 12;
    localparam int ZOOM_W  = 19;
    localparam int SLOTS   = 4;
    localparam int ADDR_W  = 5;

    // message kinds
    localparam logic [1:0] OP_MOVE    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_VIEW_LEFT   = 3'd0;
    localparam logic [2:0] REG_VIEW_TOP    = 3'd1;
    localparam logic [2:0] REG_VIEW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_VIEW_HEIGHT = 3'd3;
    localparam logic [2:0] REG_INV_ZOOM    = 3'd4;
    localparam logic [2:0] REG_ZOOM_ACTIVE = 3'd5;

    localparam logic [VIEW_W-1:0] RST_VIEW_LEFT   = 12'd0;
    localparam logic [VIEW_W-1:0] RST_VIEW_TOP    = 12'd0;
    localparam logic [VIEW_W-1:0] RST_VIEW_WIDTH  = 12'd640;
    localparam logic [VIEW_W-1:0] RST_VIEW_HEIGHT = 12'd480;
    localparam logic [ZOOM_W-1:0] ZOOM_ONE        = 19'd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord;   // mapped coordinate, low bits
        logic                      in_src;  // source point inside span
        logic                      in_map;  // mapped point inside span
    } zpim_axis_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/zpim_axis.sv =====
// ----------------------------------------------------------------------------
// zpim_axis
// One axis of the inverse zoom: maps a coordinate about the span center with
// round half away from zero, and checks source and result against the span.
// ----------------------------------------------------------------------------
`default_nettype none

module zpim_axis
    import zpim_pkg::*;
(
    input  wire logic signed [COORD_W-1:0] pos,
    input  wire logic        [VIEW_W-1:0]  org,
    input  wire logic        [VIEW_W-1:0]  len,
    input  wire logic        [ZOOM_W-1:0]  inv_zoom,
    output zpim_axis_res_t                 res
);

    logic        [13:0] c2;
    logic signed [17:0] d2;
    logic signed [37:0] prod;
    logic signed [38:0] num;
    logic        [38:0] mag;
    logic        [38:0] mag_rnd;
    logic        [21:0] rmag;
    logic signed [22:0] r;
    logic        [12:0] hi;
    logic signed [17:0] pos_e;
    logic signed [22:0] lo_r;
    logic signed [22:0] hi_r;

    always_comb begin
        c2      = {1'b0, org, 1'b0} + {2'b0, len};
        d2      = $signed({pos[COORD_W-1], pos, 1'b0}) - $signed({4'b0, c2});
        prod    = d2 * $signed({1'b0, inv_zoom});
        num     = {prod[37], prod} + $signed({9'b0, c2, 16'b0});
        mag     = num[38] ? 39'(-num) : 39'(num);
        mag_rnd = mag + 39'd65536;
        rmag    = mag_rnd[38:17];
        r       = num[38] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

        hi      = {1'b0, org} + {1'b0, len};
        pos_e   = {{2{pos[COORD_W-1]}}, pos};
        lo_r    = $signed({11'b0, org});
        hi_r    = $signed({10'b0, hi});

        res.coord  = r[COORD_W-1:0];
        res.in_src = (pos_e >= $signed({6'b0, org})) && (pos_e < $signed({5'b0, hi}));
        res.in_map = (r >= lo_r) && (r < hi_r);
    end

endmodule

`default_nettype wire

// ===== rtl/core/zoom_pointer_inverse_map.sv =====
// ----------------------------------------------------------------------------
// zoom_pointer_inverse_map
// Inverse zoom mapping of pointer requests with ring tracking per button.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                    tuser
//  s_       in   pos_x[15:0] pos_y[31:16] op[1:0] button[3:2]
//  m_       out  out_x[15:0] out_y[31:16] mapped[0] drop[1]
//  apb      in   regs at 4*i: left, top, width, height, inv_zoom, zoom_active
//
//  One request per cycle while the result is not stalled; m_tvalid rises once an
//  accepted request has passed the input register and then the result register.
//  Input register feeds one multiply per axis, compares and the result
//  register; the press record is updated when a request moves to the result.
//  aresetn is synchronous, active low; clears valids, press records, regs.
//  A stalled result holds the input register; s_tready drops only then.
// ----------------------------------------------------------------------------
`default_nettype none

module zoom_pointer_inverse_map
    import zpim_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // pos_x, pos_y
    input  wire logic [3:0]        s_tuser,   // op, button
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // out_x, out_y
    output logic [1:0]             m_tuser,   // mapped, drop
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [VIEW_W-1:0] view_left_reg, view_top_reg, view_width_reg, view_height_reg;
    logic [ZOOM_W-1:0] inv_zoom_reg;
    logic              zoom_active_reg;
    logic [2:0]        reg_idx;
    logic              cfg_wr;

    logic              in_vld_reg;
    logic [1:0]        op_reg;
    logic [1:0]        button_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;

    logic              out_vld_reg;
    logic [31:0]       out_data_reg;
    logic [1:0]        out_user_reg;

    logic [SLOTS-1:0]  dropped_reg, dropped_next;

    logic              advance;
    logic              load_out;
    zpim_axis_res_t    ax, ay;
    logic              zoom_on, in_span, ring, mapped, drop;
    logic signed [COORD_W-1:0] ox, oy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_left_reg   <= RST_VIEW_LEFT;
            view_top_reg    <= RST_VIEW_TOP;
            view_width_reg  <= RST_VIEW_WIDTH;
            view_height_reg <= RST_VIEW_HEIGHT;
            inv_zoom_reg    <= ZOOM_ONE;
            zoom_active_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_VIEW_LEFT:   view_left_reg   <= pwdata[VIEW_W-1:0];
                REG_VIEW_TOP:    view_top_reg    <= pwdata[VIEW_W-1:0];
                REG_VIEW_WIDTH:  view_width_reg  <= pwdata[VIEW_W-1:0];
                REG_VIEW_HEIGHT: view_height_reg <= pwdata[VIEW_W-1:0];
                REG_INV_ZOOM:    inv_zoom_reg    <= pwdata[ZOOM_W-1:0];
                REG_ZOOM_ACTIVE: zoom_active_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VIEW_LEFT:   prdata = {20'b0, view_left_reg};
            REG_VIEW_TOP:    prdata = {20'b0, view_top_reg};
            REG_VIEW_WIDTH:  prdata = {20'b0, view_width_reg};
            REG_VIEW_HEIGHT: prdata = {20'b0, view_height_reg};
            REG_INV_ZOOM:    prdata = {13'b0, inv_zoom_reg};
            REG_ZOOM_ACTIVE: prdata = {31'b0, zoom_active_reg};
            default:         prdata = 32'b0;
        endcase
    end

    // handshake
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign load_out = in_vld_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg     <= s_tuser[1:0];
            button_reg <= s_tuser[3:2];
            x_reg      <= s_tdata[15:0];
            y_reg      <= s_tdata[31:16];
        end
    end

    zpim_axis u_axis_x (
        .pos      (x_reg),
        .org      (view_left_reg),
        .len      (view_width_reg),
        .inv_zoom (inv_zoom_reg),
        .res      (ax)
    );

    zpim_axis u_axis_y (
        .pos      (y_reg),
        .org      (view_top_reg),
        .len      (view_height_reg),
        .inv_zoom (inv_zoom_reg),
        .res      (ay)
    );

    always_comb begin
        zoom_on = zoom_active_reg && (inv_zoom_reg != ZOOM_ONE) &&
                  (view_width_reg != '0) && (view_height_reg != '0);
        in_span = (op_reg != OP_NONE) && zoom_on && ax.in_src && ay.in_src;
        ring    = in_span && !(ax.in_map && ay.in_map);
        mapped  = in_span && ax.in_map && ay.in_map;
        ox      = mapped ? ax.coord : x_reg;
        oy      = mapped ? ay.coord : y_reg;

        dropped_next = dropped_reg;
        case (op_reg)
            OP_PRESS: begin
                drop = ring;
                dropped_next[button_reg] = ring;
            end
            OP_RELEASE: begin
                drop = dropped_reg[button_reg];
                dropped_next[button_reg] = 1'b0;
            end
            default: begin
                drop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dropped_reg <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (load_out) begin
                dropped_reg <= dropped_next;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {oy, ox};
            out_user_reg <= {drop, mapped};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_rst_clears_press: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> dropped_reg == '0)
        else $error("press record not cleared by reset");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && op_reg == OP_RELEASE) |=> !dropped_reg[$past(button_reg)])
        else $error("release left its press record set");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/zoom_pointer_inverse_map_tb.sv =====
// ----------------------------------------------------------------------------
// zoom_pointer_inverse_map_tb
// Drives pointer requests through the inverse zoom mapper under random
// source gaps and sink stalls. A local predictor mirrors the register file and
// the per-button ring record, and each result is checked in order against it.
// Directed cases cover pass-through, rounding and ring handling; the bulk is
// random press/move/release gestures over several viewport and zoom settings.
// ----------------------------------------------------------------------------
module zoom_pointer_inverse_map_tb;
    import zpim_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_WAIT      = 14;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 9;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      mapped;
        logic                      drop;
    } pointer_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;   // pos_x[15:0], pos_y[31:16]
    logic [3:0]        s_tuser  = '0;   // op[1:0], button[3:2]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // out_x[15:0], out_y[31:16]
    logic [1:0]        m_tuser;         // mapped[0], drop[1]
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // predictor copy of registers and press record
    logic [VIEW_W-1:0] view_left_q   = RST_VIEW_LEFT;
    logic [VIEW_W-1:0] view_top_q    = RST_VIEW_TOP;
    logic [VIEW_W-1:0] view_width_q  = RST_VIEW_WIDTH;
    logic [VIEW_W-1:0] view_height_q = RST_VIEW_HEIGHT;
    logic [ZOOM_W-1:0] inv_zoom_q    = ZOOM_ONE;
    logic              zoom_on_q     = 1'b0;
    logic [SLOTS-1:0]  press_in_ring = '0;

    pointer_result_t expected_results[$];
    pointer_result_t want;
    int              failures   = 0;
    int              sent_count = 0;
    int              quiet      = 0;
    logic            idle_off   = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    zoom_pointer_inverse_map dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic logic point_in_view(longint px, longint py);
        return px >= longint'(view_left_q) && py >= longint'(view_top_q) &&
               px < longint'(view_left_q) + longint'(view_width_q) &&
               py < longint'(view_top_q) + longint'(view_height_q);
    endfunction

    // exact mapping in units of 2^-17, rounded half away from zero
    function automatic longint unzoom_axis(longint p, longint org, longint len);
        longint c2, num, mag, r;
        c2  = 2 * org + len;
        num = (2 * p - c2) * longint'(inv_zoom_q) + c2 * 65536;
        mag = (num < 0) ? -num : num;
        r   = (mag + 65536) >>> 17;
        return (num < 0) ? -r : r;
    endfunction

    function automatic pointer_result_t predict_pointer(input logic [1:0] op,
            input logic [1:0] slot, input logic signed [COORD_W-1:0] px,
            input logic signed [COORD_W-1:0] py);
        pointer_result_t res;
        longint          ux, uy;
        logic            ring;
        res.x      = px;
        res.y      = py;
        res.mapped = 1'b0;
        res.drop   = 1'b0;
        ring       = 1'b0;
        if (op != OP_NONE && zoom_on_q && inv_zoom_q != ZOOM_ONE &&
            view_width_q != 0 && view_height_q != 0 &&
            point_in_view(longint'(px), longint'(py))) begin
            ux = unzoom_axis(longint'(px), longint'(view_left_q), longint'(view_width_q));
            uy = unzoom_axis(longint'(py), longint'(view_top_q), longint'(view_height_q));
            if (point_in_view(ux, uy)) begin
                res.x      = ux[COORD_W-1:0];
                res.y      = uy[COORD_W-1:0];
                res.mapped = 1'b1;
            end else begin
                ring = 1'b1;
            end
        end
        if (op == OP_PRESS) begin
            press_in_ring[slot] = ring;
            res.drop            = ring;
        end else if (op == OP_RELEASE) begin
            res.drop            = press_in_ring[slot];
            press_in_ring[slot] = 1'b0;
        end
        return res;
    endfunction

    // register writes and accepted requests feed the predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            view_left_q   = RST_VIEW_LEFT;
            view_top_q    = RST_VIEW_TOP;
            view_width_q  = RST_VIEW_WIDTH;
            view_height_q = RST_VIEW_HEIGHT;
            inv_zoom_q    = ZOOM_ONE;
            zoom_on_q     = 1'b0;
            press_in_ring = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_VIEW_LEFT:   view_left_q   = pwdata[VIEW_W-1:0];
                    REG_VIEW_TOP:    view_top_q    = pwdata[VIEW_W-1:0];
                    REG_VIEW_WIDTH:  view_width_q  = pwdata[VIEW_W-1:0];
                    REG_VIEW_HEIGHT: view_height_q = pwdata[VIEW_W-1:0];
                    REG_INV_ZOOM:    inv_zoom_q    = pwdata[ZOOM_W-1:0];
                    REG_ZOOM_ACTIVE: zoom_on_q     = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_pointer(s_tuser[1:0], s_tuser[3:2],
                                                           s_tdata[15:0], s_tdata[31:16]));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: out_x %0d out_y %0d mapped %0b drop %0b",
                       $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                       m_tuser[0], m_tuser[1]);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (want.x !== m_tdata[15:0]) begin
                    $error("out_x: expected %0d, got %0d", want.x, $signed(m_tdata[15:0]));
                    failures++;
                end
                if (want.y !== m_tdata[31:16]) begin
                    $error("out_y: expected %0d, got %0d", want.y, $signed(m_tdata[31:16]));
                    failures++;
                end
                if (want.mapped !== m_tuser[0]) begin
                    $error("mapped: expected %0b, got %0b", want.mapped, m_tuser[0]);
                    failures++;
                end
                if (want.drop !== m_tuser[1]) begin
                    $error("drop: expected %0b, got %0b", want.drop, m_tuser[1]);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("** zoom_pointer_inverse_map: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int draw_wait();
        return idle_off ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // result sink with random stalls
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [1:0] slot,
                                input logic signed [COORD_W-1:0] px,
                                input logic signed [COORD_W-1:0] py);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tuser  <= {slot, op};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic configure(input int left, input int top, input int w, input int h,
                             input int iz, input int active);
        wait_drained();
        write_reg(REG_VIEW_LEFT, left);
        write_reg(REG_VIEW_TOP, top);
        write_reg(REG_VIEW_WIDTH, w);
        write_reg(REG_VIEW_HEIGHT, h);
        write_reg(REG_INV_ZOOM, iz);
        write_reg(REG_ZOOM_ACTIVE, active);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly inside the view, some near its edges, some anywhere
    function automatic logic signed [COORD_W-1:0] pick_coord(input int org, input int len);
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            v = org + $urandom_range(0, len - 1);
        else if (sel < 80)
            v = ($urandom_range(0, 1) ? org : org + len) + $urandom_range(0, 4) - 2;
        else if (sel < 92)
            v = $urandom_range(0, 65535);
        else begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 0;
                default: v = -1;
            endcase
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic void pick_point(output logic signed [COORD_W-1:0] px,
                                       output logic signed [COORD_W-1:0] py);
        px = pick_coord(int'(view_left_q), int'(view_width_q));
        py = pick_coord(int'(view_top_q), int'(view_height_q));
    endfunction

    task automatic send_gesture();
        logic [1:0]                slot;
        logic signed [COORD_W-1:0] px, py;
        int                        moves;
        slot = 2'($urandom_range(0, 3));
        pick_point(px, py);
        send_request(OP_PRESS, slot, px, py);
        if ($urandom_range(0, 5) == 0)
            send_request(OP_PRESS, slot, px, py);
        moves = $urandom_range(0, 3);
        repeat (moves) begin
            pick_point(px, py);
            send_request(OP_MOVE, 2'($urandom_range(0, 3)), px, py);
        end
        pick_point(px, py);
        send_request(OP_RELEASE, slot, px, py);
    endtask

    task automatic send_noise();
        logic signed [COORD_W-1:0] px, py;
        if ($urandom_range(0, 1)) begin
            pick_point(px, py);
        end else begin
            px = 16'($urandom_range(0, 65535));
            py = 16'($urandom_range(0, 65535));
        end
        send_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), px, py);
    endtask

    // reset registers: zoom off, everything passes through with drop low
    task automatic test_zoom_off_passthrough();
        send_request(OP_MOVE, 2'd0, -16'sd32768, -16'sd32768);
        send_request(OP_MOVE, 2'd3, 16'sd32767, 16'sd32767);
        send_request(OP_NONE, 2'd2, 16'sd320, 16'sd240);
        send_request(OP_PRESS, 2'd0, 16'sd0, 16'sd0);
        send_request(OP_PRESS, 2'd3, 16'sd639, 16'sd479);
        send_request(OP_RELEASE, 2'd0, -16'sd1, -16'sd1);
        send_request(OP_RELEASE, 2'd3, 16'sd32767, -16'sd32768);
        send_request(OP_MOVE, 2'd1, 16'sd100, 16'sd100);
    endtask

    task automatic test_zoom_directed();
        // view 100,50 640x480, zoom one half: centre 420,290
        configure(100, 50, 640, 480, 131072, 1);
        send_request(OP_MOVE, 2'd0, 16'sd420, 16'sd290);
        send_request(OP_MOVE, 2'd0, 16'sd421, 16'sd291);
        send_request(OP_PRESS, 2'd0, 16'sd100, 16'sd50);      // ring press
        send_request(OP_RELEASE, 2'd0, 16'sd420, 16'sd290);   // reports ring
        send_request(OP_RELEASE, 2'd0, 16'sd420, 16'sd290);   // record cleared
        send_request(OP_PRESS, 2'd1, 16'sd420, 16'sd290);
        send_request(OP_RELEASE, 2'd1, 16'sd5000, -16'sd5000);
        send_request(OP_MOVE, 2'd2, 16'sd99, 16'sd290);       // just left of view
        send_request(OP_MOVE, 2'd2, 16'sd739, 16'sd290);      // last column, rings
        send_request(OP_MOVE, 2'd2, 16'sd420, 16'sd530);      // just below view
        send_request(OP_NONE, 2'd1, 16'sd420, 16'sd290);
        send_request(OP_PRESS, 2'd3, 16'sd739, 16'sd529);     // ring press kept
        send_request(OP_PRESS, 2'd2, 16'sd420, 16'sd290);     // double click
        send_request(OP_PRESS, 2'd2, 16'sd420, 16'sd290);
        // zoom 1/1.5 at origin: exact halves round away from zero
        configure(0, 0, 640, 480, 98304, 1);
        send_request(OP_MOVE, 2'd0, 16'sd321, 16'sd241);
        send_request(OP_RELEASE, 2'd3, 16'sd0, 16'sd0);       // record survives config
        configure(0, 0, 640, 480, int'(ZOOM_ONE), 1);
        send_request(OP_MOVE, 2'd0, 16'sd321, 16'sd241);
        configure(0, 0, 640, 480, 131072, 0);
        send_request(OP_MOVE, 2'd0, 16'sd321, 16'sd241);
    endtask

    task automatic test_random_gestures();
        int   phase_start;
        logic paused;
        paused = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(0, 0, 640, 480, 131072, 1);
                1: configure(0, 0, 1, 1, 8192, 1);
                2: configure(4095, 4095, 4095, 4095, 262144, 1);
                3: configure(0, 0, 4095, 4095, 8192, 1);
                4: configure(4095, 0, 1, 4095, 262144, 1);
                5: configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(1, 4095), $urandom_range(1, 4095),
                             $urandom_range(8192, 262144), 0);
                default: configure($urandom_range(0, 2000), $urandom_range(0, 2000),
                                   $urandom_range(1, 1500), $urandom_range(1, 1500),
                                   $urandom_range(8192, 262144), 1);
            endcase
            idle_off = (ph == 6);
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                if (ph == 4 && !paused && sent_count - phase_start >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) < 7)
                    send_gesture();
                else
                    send_noise();
            end
        end
        idle_off = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zoom_off_passthrough();
        test_zoom_directed();
        test_random_gestures();
        wait_drained();
        if (failures == 0 && expected_results.size() == 0)
            $display("** zoom_pointer_inverse_map: PASSED **");
        else
            $display("** zoom_pointer_inverse_map: FAILED **");
        $finish;
    end

endmodule
